// ----- sv/scc_pkg.sv -----
// Shared types and constants for the stereo capture controller.
// Holds the request, phase and fault codes and the result record.
// No dependencies.
`timescale 1ns / 1ps

package scc_pkg;

    localparam int unsigned COUNT_W            = 25;
    localparam int unsigned ADDR_W             = 24;
    localparam int unsigned TIME_W             = 32;
    localparam int unsigned SAMPLE_W           = 32;
    localparam int unsigned MAX_FRAMES_DEFAULT = 16777216;

    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 25'd2160000;

    typedef enum logic [2:0] {
        REQ_START    = 3'd0,
        REQ_STOP     = 3'd1,
        REQ_CANCEL   = 3'd2,
        REQ_XRUN     = 3'd3,
        REQ_SHUTDOWN = 3'd4,
        REQ_FRAME    = 3'd5
    } req_t;

    typedef enum logic [2:0] {
        PH_READY     = 3'd0,
        PH_ARMED     = 3'd1,
        PH_CAPTURING = 3'd2,
        PH_STOPREQ   = 3'd3,
        PH_COMPLETED = 3'd4,
        PH_CANCELLED = 3'd5,
        PH_FAILED    = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        FLT_NONE     = 2'd0,
        FLT_XRUN     = 2'd1,
        FLT_GAP      = 2'd2,
        FLT_SHUTDOWN = 2'd3
    } fault_t;

    typedef struct packed {
        phase_t              phase;
        fault_t              fault;
        logic                accepted;
        logic [COUNT_W-1:0]  frames_stored;
        logic [TIME_W-1:0]   first_time;
        logic [TIME_W-1:0]   last_time;
        logic                store_en;
        logic [ADDR_W-1:0]   store_addr;
        logic [SAMPLE_W-1:0] store_left;
        logic [SAMPLE_W-1:0] store_right;
    } result_t;

endpackage

// ----- sv/scc_core.sv -----
// Capture state machine with its state registers and the capacity register.
// Computes the result record of each accepted transaction in one pass.
// Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_core
    import scc_pkg::*;
#(
    parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [COUNT_W-1:0]  cfg_wr_data,
    input  logic                accept,
    input  logic [2:0]          req_type,
    input  logic                block_start,
    input  logic [TIME_W-1:0]   block_stamp,
    input  logic [SAMPLE_W-1:0] left_sample,
    input  logic [SAMPLE_W-1:0] right_sample,
    output result_t             result
);

    localparam logic [COUNT_W-1:0] MAX_CAP = COUNT_W'(MAX_FRAMES);

    logic [COUNT_W-1:0] capacity_reg;
    phase_t             phase_reg;
    phase_t             phase_next;
    fault_t             fault_reg;
    fault_t             fault_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [TIME_W-1:0]  begin_time_reg;
    logic [TIME_W-1:0]  begin_time_next;
    logic [TIME_W-1:0]  end_time_reg;
    logic [TIME_W-1:0]  end_time_next;
    logic [TIME_W-1:0]  expect_reg;
    logic [TIME_W-1:0]  expect_next;
    logic               live_reg;
    logic               live_next;
    logic [COUNT_W-1:0] cap;
    logic               active;

    assign cap    = (capacity_reg > MAX_CAP) ? MAX_CAP : capacity_reg;
    assign active = (phase_reg == PH_ARMED) || (phase_reg == PH_CAPTURING)
                    || (phase_reg == PH_STOPREQ);

    always_comb
    begin
        phase_next      = phase_reg;
        fault_next      = fault_reg;
        count_next      = count_reg;
        begin_time_next = begin_time_reg;
        end_time_next   = end_time_reg;
        expect_next     = expect_reg;
        live_next       = live_reg;
        result          = '0;

        case (req_type)
            REQ_START:
            begin
                if (phase_reg == PH_READY)
                begin
                    phase_next      = PH_ARMED;
                    result.accepted = 1'b1;
                end
            end
            REQ_STOP:
            begin
                if (phase_reg == PH_ARMED || phase_reg == PH_CAPTURING)
                begin
                    phase_next      = PH_STOPREQ;
                    result.accepted = 1'b1;
                end
            end
            REQ_CANCEL:
            begin
                if (active)
                begin
                    phase_next      = PH_CANCELLED;
                    live_next       = 1'b0;
                    result.accepted = 1'b1;
                end
            end
            REQ_XRUN:
            begin
                if (active)
                begin
                    phase_next = PH_FAILED;
                    fault_next = FLT_XRUN;
                    live_next  = 1'b0;
                end
            end
            REQ_SHUTDOWN:
            begin
                if (active)
                begin
                    phase_next = PH_FAILED;
                    fault_next = FLT_SHUTDOWN;
                    live_next  = 1'b0;
                end
            end
            REQ_FRAME:
            begin
                if (block_start)
                begin
                    live_next = 1'b0;
                    if (phase_reg == PH_ARMED)
                    begin
                        phase_next      = PH_CAPTURING;
                        begin_time_next = block_stamp;
                        end_time_next   = block_stamp;
                        expect_next     = block_stamp;
                        count_next      = '0;
                    end
                    if (phase_next == PH_STOPREQ)
                    begin
                        phase_next = PH_COMPLETED;
                    end
                    else if (phase_next == PH_CAPTURING)
                    begin
                        if (block_stamp != expect_next)
                        begin
                            phase_next = PH_FAILED;
                            fault_next = FLT_GAP;
                        end
                        else
                        begin
                            live_next = 1'b1;
                        end
                    end
                end
                if (phase_next == PH_CAPTURING && live_next)
                begin
                    if (count_next >= cap)
                    begin
                        phase_next = PH_COMPLETED;
                        live_next  = 1'b0;
                    end
                    else
                    begin
                        result.store_en    = 1'b1;
                        result.store_addr  = count_next[ADDR_W-1:0];
                        result.store_left  = left_sample;
                        result.store_right = right_sample;
                        count_next         = count_next + 1'b1;
                        expect_next        = expect_next + 1'b1;
                        end_time_next      = expect_next;
                        if (count_next >= cap)
                        begin
                            phase_next = PH_COMPLETED;
                            live_next  = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        result.phase         = phase_next;
        result.fault         = fault_next;
        result.frames_stored = count_next;
        result.first_time    = begin_time_next;
        result.last_time     = end_time_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_READY;
            fault_reg      <= FLT_NONE;
            count_reg      <= '0;
            begin_time_reg <= '0;
            end_time_reg   <= '0;
            expect_reg     <= '0;
            live_reg       <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            fault_reg      <= fault_next;
            count_reg      <= count_next;
            begin_time_reg <= begin_time_next;
            end_time_reg   <= end_time_next;
            expect_reg     <= expect_next;
            live_reg       <= live_next;
        end
    end

endmodule

// ----- sv/scc_out_buf.sv -----
// Two-entry output buffer: the result register plus a skid register.
// Lets a new transaction enter while a finished result is still stalled.
// Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_out_buf
    import scc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    result_t head_reg;
    result_t skid_reg;
    logic    head_valid_reg;
    logic    head_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    logic    pop;
    logic    load_head_from_skid;
    logic    load_head_from_push;
    logic    load_skid;

    assign pop       = head_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

    always_comb
    begin
        head_valid_next     = head_valid_reg;
        skid_valid_next     = skid_valid_reg;
        load_head_from_skid = 1'b0;
        load_head_from_push = 1'b0;
        load_skid           = 1'b0;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                load_head_from_skid = 1'b1;
                skid_valid_next     = 1'b0;
            end
        end
        else if (!head_valid_reg || pop)
        begin
            load_head_from_push = push;
            head_valid_next     = push;
        end
        else if (push)
        begin
            load_skid       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_head_from_skid)
        begin
            head_reg <= skid_reg;
        end
        else if (load_head_from_push)
        begin
            head_reg <= push_data;
        end
        if (load_skid)
        begin
            skid_reg <= push_data;
        end
    end

endmodule

// ----- sv/stereo_capture_controller.sv -----
// Stereo capture controller: top level joining the state machine and the output buffer.
// Each accepted result is registered in the output buffer before it is offered.
// Throughput: one transaction per cycle; the input stalls only when both output entries are full.
// Reset: asynchronous, active low; phase ready, all counters and times zero,
// capacity 2160000, output buffer empty.
`timescale 1ns / 1ps

module stereo_capture_controller
    import scc_pkg::*;
#(
    parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [COUNT_W-1:0]  cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          req_type,
    input  logic                block_start,
    input  logic [TIME_W-1:0]   block_stamp,
    input  logic [SAMPLE_W-1:0] left_sample,
    input  logic [SAMPLE_W-1:0] right_sample,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          phase,
    output logic [1:0]          fault_code,
    output logic                command_accepted,
    output logic [COUNT_W-1:0]  frames_stored,
    output logic [TIME_W-1:0]   first_frame_time,
    output logic [TIME_W-1:0]   last_frame_time,
    output logic                store_enable,
    output logic [ADDR_W-1:0]   store_address,
    output logic [SAMPLE_W-1:0] store_left,
    output logic [SAMPLE_W-1:0] store_right
);

    logic    accept;
    logic    buf_full;
    result_t core_result;
    result_t out_result;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    scc_core #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .accept       (accept),
        .req_type     (req_type),
        .block_start  (block_start),
        .block_stamp  (block_stamp),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .result       (core_result)
    );

    scc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (core_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_result)
    );

    assign phase            = out_result.phase;
    assign fault_code       = out_result.fault;
    assign command_accepted = out_result.accepted;
    assign frames_stored    = out_result.frames_stored;
    assign first_frame_time = out_result.first_time;
    assign last_frame_time  = out_result.last_time;
    assign store_enable     = out_result.store_en;
    assign store_address    = out_result.store_addr;
    assign store_left       = out_result.store_left;
    assign store_right      = out_result.store_right;

endmodule

// ----- verif/scc_capture_checker.sv -----
// Checker for the stereo capture controller: watches the configuration port and both channels.
// Predicts each result from the accepted transactions and compares it field by field.
// Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_capture_checker
    import scc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [COUNT_W-1:0]  cfg_wr_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [2:0]          req_type,
    input  logic                block_start,
    input  logic [TIME_W-1:0]   block_stamp,
    input  logic [SAMPLE_W-1:0] left_sample,
    input  logic [SAMPLE_W-1:0] right_sample,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [2:0]          phase,
    input  logic [1:0]          fault_code,
    input  logic                command_accepted,
    input  logic [COUNT_W-1:0]  frames_stored,
    input  logic [TIME_W-1:0]   first_frame_time,
    input  logic [TIME_W-1:0]   last_frame_time,
    input  logic                store_enable,
    input  logic [ADDR_W-1:0]   store_address,
    input  logic [SAMPLE_W-1:0] store_left,
    input  logic [SAMPLE_W-1:0] store_right,
    output int unsigned         fail_count,
    output int unsigned         outstanding
);

    logic [COUNT_W-1:0] capacity;
    phase_t             phase_now;
    fault_t             fault_now;
    logic [COUNT_W-1:0] stored;
    logic [TIME_W-1:0]  t_first;
    logic [TIME_W-1:0]  t_last;
    logic [TIME_W-1:0]  t_next;
    logic               live;
    result_t            expected_results[$];

    function automatic bit capture_active();
        return phase_now inside {PH_ARMED, PH_CAPTURING, PH_STOPREQ};
    endfunction

    function automatic void abort_capture(input fault_t code);
        if (capture_active())
        begin
            phase_now = PH_FAILED;
            fault_now = code;
            live      = 1'b0;
        end
    endfunction

    function automatic result_t advance_capture(
        input logic [2:0]          kind,
        input logic                bstart,
        input logic [TIME_W-1:0]   ftime,
        input logic [SAMPLE_W-1:0] lsamp,
        input logic [SAMPLE_W-1:0] rsamp
    );
        result_t            r;
        logic [COUNT_W-1:0] limit;
        r     = '0;
        limit = (capacity > COUNT_W'(MAX_FRAMES_DEFAULT)) ? COUNT_W'(MAX_FRAMES_DEFAULT)
                                                          : capacity;
        case (kind)
            REQ_START:
            begin
                if (phase_now == PH_READY)
                begin
                    phase_now  = PH_ARMED;
                    r.accepted = 1'b1;
                end
            end
            REQ_STOP:
            begin
                if (phase_now == PH_ARMED || phase_now == PH_CAPTURING)
                begin
                    phase_now  = PH_STOPREQ;
                    r.accepted = 1'b1;
                end
            end
            REQ_CANCEL:
            begin
                if (capture_active())
                begin
                    phase_now  = PH_CANCELLED;
                    live       = 1'b0;
                    r.accepted = 1'b1;
                end
            end
            REQ_XRUN:     abort_capture(FLT_XRUN);
            REQ_SHUTDOWN: abort_capture(FLT_SHUTDOWN);
            REQ_FRAME:
            begin
                if (bstart)
                begin
                    live = 1'b0;
                    if (phase_now == PH_ARMED)
                    begin
                        phase_now = PH_CAPTURING;
                        t_first   = ftime;
                        t_last    = ftime;
                        t_next    = ftime;
                        stored    = '0;
                    end
                    if (phase_now == PH_STOPREQ)
                        phase_now = PH_COMPLETED;
                    else if (phase_now == PH_CAPTURING)
                    begin
                        if (ftime != t_next)
                            abort_capture(FLT_GAP);
                        else
                            live = 1'b1;
                    end
                end
                if (phase_now == PH_CAPTURING && live)
                begin
                    if (stored >= limit)
                    begin
                        phase_now = PH_COMPLETED;
                        live      = 1'b0;
                    end
                    else
                    begin
                        r.store_en    = 1'b1;
                        r.store_addr  = stored[ADDR_W-1:0];
                        r.store_left  = lsamp;
                        r.store_right = rsamp;
                        stored        = stored + 1'b1;
                        t_next        = t_next + 1'b1;
                        t_last        = t_next;
                        if (stored >= limit)
                        begin
                            phase_now = PH_COMPLETED;
                            live      = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.phase         = phase_now;
        r.fault         = fault_now;
        r.frames_stored = stored;
        r.first_time    = t_first;
        r.last_time     = t_last;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            capacity    = CAPACITY_RESET;
            phase_now   = PH_READY;
            fault_now   = FLT_NONE;
            stored      = '0;
            t_first     = '0;
            t_last      = '0;
            t_next      = '0;
            live        = 1'b0;
            fail_count  = 0;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                capacity = cfg_wr_data;
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no expected result waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("phase", 32'(want.phase), 32'(phase));
                    compare_field("fault_code", 32'(want.fault), 32'(fault_code));
                    compare_field("command_accepted", 32'(want.accepted),
                                  32'(command_accepted));
                    compare_field("frames_stored", 32'(want.frames_stored),
                                  32'(frames_stored));
                    compare_field("first_frame_time", want.first_time, first_frame_time);
                    compare_field("last_frame_time", want.last_time, last_frame_time);
                    compare_field("store_enable", 32'(want.store_en), 32'(store_enable));
                    compare_field("store_address", 32'(want.store_addr),
                                  32'(store_address));
                    compare_field("store_left", want.store_left, store_left);
                    compare_field("store_right", want.store_right, store_right);
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(advance_capture(req_type, block_start, block_stamp,
                                                           left_sample, right_sample));
            outstanding <= expected_results.size();
        end
    end

endmodule

// ----- verif/tb_stereo_capture_controller.sv -----
// Top of the stereo capture controller testbench: clock, reset, stimulus and verdict.
// Depends on scc_pkg, stereo_capture_controller and scc_capture_checker.
`timescale 1ns / 1ps

module tb_stereo_capture_controller
    import scc_pkg::*;
();

    localparam logic [2:0] REQ_UNKNOWN_A = 3'd6;
    localparam logic [2:0] REQ_UNKNOWN_B = 3'd7;
    localparam int unsigned LONG_HOLD = 64;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0]  cfg_wr_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [2:0]          req_type = REQ_FRAME;
    logic                block_start = 1'b0;
    logic [TIME_W-1:0]   block_stamp = '0;
    logic [SAMPLE_W-1:0] left_sample = '0;
    logic [SAMPLE_W-1:0] right_sample = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [2:0]          phase;
    logic [1:0]          fault_code;
    logic                command_accepted;
    logic [COUNT_W-1:0]  frames_stored;
    logic [TIME_W-1:0]   first_frame_time;
    logic [TIME_W-1:0]   last_frame_time;
    logic                store_enable;
    logic [ADDR_W-1:0]   store_address;
    logic [SAMPLE_W-1:0] store_left;
    logic [SAMPLE_W-1:0] store_right;
    int unsigned         fail_count;
    int unsigned         outstanding;

    int unsigned         send_idle_pct = 37;
    int unsigned         recv_idle_pct = 60;
    bit                  hold_request = 1'b0;
    int unsigned         hold_count = 0;
    int unsigned         items_offered = 0;
    logic [TIME_W-1:0]   stream_time = '0;
    int unsigned         capture_count = 0;

    stereo_capture_controller i_dut (.*);

    scc_capture_checker i_checker (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_count   = LONG_HOLD;
            end
            if (hold_count != 0)
            begin
                out_stall <= 1'b1;
                hold_count--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] noop_request();
        case ($urandom_range(2))
            0:       return REQ_START;
            1:       return REQ_UNKNOWN_A;
            default: return REQ_UNKNOWN_B;
        endcase
    endfunction

    task automatic offer(input logic [2:0] kind, input logic bstart,
                         input logic [TIME_W-1:0] ftime, input logic [SAMPLE_W-1:0] lsamp,
                         input logic [SAMPLE_W-1:0] rsamp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        block_start  <= bstart;
        block_stamp  <= ftime;
        left_sample  <= lsamp;
        right_sample <= rsamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_offered++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [COUNT_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic frame_block(input int unsigned len);
        offer(REQ_FRAME, 1'b1, stream_time, pick_word(), pick_word());
        stream_time++;
        capture_count++;
        for (int i = 1; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                offer(noop_request(), 1'($urandom), $urandom, $urandom, $urandom);
            offer(REQ_FRAME, 1'b0, $urandom, pick_word(), pick_word());
            stream_time++;
            capture_count++;
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_capacity('0);
        offer(REQ_UNKNOWN_A, 1'b0, '0, '0, '0);
        offer(REQ_UNKNOWN_B, 1'b1, '1, '1, '1);
        offer(REQ_STOP, 1'b0, '0, '0, '0);
        offer(REQ_CANCEL, 1'b0, '0, '0, '0);
        offer(REQ_XRUN, 1'b0, '0, '0, '0);
        offer(REQ_SHUTDOWN, 1'b0, '0, '0, '0);
        offer(REQ_FRAME, 1'b1, '1, '1, '1);
        offer(REQ_FRAME, 1'b0, '0, '0, '0);

        write_capacity('1);
        offer(REQ_START, 1'b0, '0, '0, '0);
        offer(REQ_START, 1'b0, '0, '0, '0);
        offer(REQ_FRAME, 1'b0, '1, '1, '1);
        offer(REQ_UNKNOWN_B, 1'b0, '0, '0, '0);
        offer(REQ_FRAME, 1'b1, 32'hFFFF_FFFE, '0, '1);
        offer(REQ_FRAME, 1'b0, '0, '1, '0);
        offer(REQ_UNKNOWN_A, 1'b1, '1, '1, '1);
        offer(REQ_FRAME, 1'b0, '1, 32'h8000_0000, 32'h7FFF_FFFF);
        stream_time   = 32'h0000_0001;
        capture_count = 3;
        frame_block(2);

        while (items_offered < 360)
            frame_block($urandom_range(1, 8));

        send_idle_pct = 60;
        recv_idle_pct = 37;
        write_capacity(COUNT_W'(MAX_FRAMES_DEFAULT));
        while (items_offered < 700)
            frame_block($urandom_range(1, 8));

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_capacity(COUNT_W'($urandom_range(2000, 25'h1FF_FFFF)));
        while (items_offered < 800)
            frame_block($urandom_range(1, 8));
        hold_request = 1'b1;
        while (items_offered < 1050)
            frame_block($urandom_range(1, 8));

        // The capture can end only once per run, so the seed picks how it ends.
        case ($urandom_range(8))
            0:
            begin
                offer(REQ_STOP, 1'b0, '0, '0, '0);
                offer(REQ_FRAME, 1'b0, $urandom, $urandom, $urandom);
                offer(REQ_STOP, 1'b0, '0, '0, '0);
                frame_block(3);
            end
            1:
            begin
                offer(REQ_STOP, 1'b0, '0, '0, '0);
                offer(REQ_XRUN, 1'b0, '0, '0, '0);
            end
            2:
            begin
                offer(REQ_STOP, 1'b0, '0, '0, '0);
                offer(REQ_CANCEL, 1'b0, '0, '0, '0);
            end
            3:
            begin
                offer(REQ_CANCEL, 1'b0, '0, '0, '0);
                frame_block(3);
            end
            4:
            begin
                offer(REQ_XRUN, 1'b0, '0, '0, '0);
                frame_block(2);
            end
            5:
            begin
                offer(REQ_SHUTDOWN, 1'b0, '0, '0, '0);
                frame_block(2);
            end
            6:
            begin
                offer(REQ_FRAME, 1'b1, stream_time ^ (32'd1 << $urandom_range(31)),
                      $urandom, $urandom);
                frame_block(2);
            end
            7:
            begin
                write_capacity(COUNT_W'(capture_count + $urandom_range(1, 6)));
                frame_block(4);
                frame_block(4);
            end
            default:
            begin
                write_capacity(COUNT_W'($urandom_range(0, capture_count)));
                frame_block(2);
            end
        endcase

        offer(REQ_XRUN, 1'b0, '0, '0, '0);
        offer(REQ_SHUTDOWN, 1'b0, '0, '0, '0);
        offer(REQ_START, 1'b0, '0, '0, '0);
        offer(REQ_STOP, 1'b0, '0, '0, '0);
        offer(REQ_CANCEL, 1'b0, '0, '0, '0);
        offer(REQ_FRAME, 1'b1, stream_time, $urandom, $urandom);
        offer(REQ_FRAME, 1'b0, $urandom, $urandom, $urandom);
        drain();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
